FILE: hw/rtl/uedf_pkg.sv
// ----------------------------------------------------------------------------
// uedf_pkg
// Shared widths, result codes, register indices, reset values and the result record of the packet deframer.
// ----------------------------------------------------------------------------
package uedf_pkg;

    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 16;
    localparam int KIND_W  = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [KIND_W-1:0] KIND_PARAM   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_GOOD    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BAD_SUM = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LEN_ERR = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TIMEOUT = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PARAMS  = 2'd2;

    localparam logic [BYTE_W-1:0] START_BYTE_RST  = 8'd170;
    localparam logic [WORD_W-1:0] TIMEOUT_RST     = 16'd1000;
    localparam logic [WORD_W-1:0] MAX_PARAMS_RST  = 16'd255;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] param_byte;
        logic [WORD_W-1:0] param_index;
        logic [BYTE_W-1:0] packet_opcode;
        logic [WORD_W-1:0] param_count;
        logic              last;
    } t_result;

endpackage

FILE: hw/rtl/uedf_if.sv
// ----------------------------------------------------------------------------
// uedf_if
// Valid/ready channels of the packet deframer: input requests, results and
// register writes.
// ----------------------------------------------------------------------------
interface uedf_in_if import uedf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              action;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output action, output rx_byte, input ready);
    modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface uedf_out_if import uedf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] param_byte;
    logic [WORD_W-1:0] param_index;
    logic [BYTE_W-1:0] packet_opcode;
    logic [WORD_W-1:0] param_count;
    logic              last;

    modport source (output valid, output kind, output param_byte, output param_index,
                    output packet_opcode, output param_count, output last,
                    input ready);
    modport sink   (input valid, input kind, input param_byte, input param_index,
                    input packet_opcode, input param_count, input last,
                    output ready);
endinterface

interface uedf_cfg_if import uedf_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [WORD_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/uart_event_packet_deframer.sv
// ----------------------------------------------------------------------------
// uart_event_packet_deframer
// Deframes start/length/opcode/params/checksum packets from a byte and tick
// stream; streams parameter bytes and reports one final status per packet.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                          accepted
//  i_req    in   action, rx_byte                                  valid & ready
//  o_res    out  kind, param_byte, param_index, packet_opcode,    valid & ready
//                param_count, last
//  i_cfg    in   index, data                                      valid & ready
//
//  one request per cycle while the result channel is not stalled; a result leaves through
//  request register, one pass of packet state logic, result register
//  i_rst_n is synchronous, active low; control and register-file registers return to their reset values
//  a stalled result holds the request register, which then holds i_req
//  register writes are always ready
// ----------------------------------------------------------------------------
module uart_event_packet_deframer import uedf_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    uedf_in_if.sink        i_req,
    uedf_out_if.source     o_res,
    uedf_cfg_if.sink       i_cfg
);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_LEN_HI = 3'd1;
    localparam logic [2:0] PH_LEN_LO = 3'd2;
    localparam logic [2:0] PH_OPCODE = 3'd3;
    localparam logic [2:0] PH_PARAMS = 3'd4;
    localparam logic [2:0] PH_CHECK  = 3'd5;

    logic [BYTE_W-1:0] r_start_byte;
    logic [WORD_W-1:0] r_timeout_reload;
    logic [WORD_W-1:0] r_max_params;

    logic              r_in_valid;
    logic              r_in_action;
    logic [BYTE_W-1:0] r_in_byte;

    logic [2:0]        r_phase,    n_phase;
    logic [WORD_W-1:0] r_count,    n_count;
    logic [BYTE_W-1:0] r_len_hi,   n_len_hi;
    logic [WORD_W-1:0] r_expected, n_expected;
    logic [WORD_W-1:0] r_received, n_received;
    logic [BYTE_W-1:0] r_opcode,   n_opcode;
    logic [BYTE_W-1:0] r_sum,      n_sum;

    logic              r_out_valid;
    t_result           r_out;
    t_result           n_res;
    logic              n_res_valid;

    logic              advance;
    logic [WORD_W-1:0] count_dec;
    logic [WORD_W-1:0] length;
    logic [WORD_W-1:0] length_m1;
    logic [WORD_W-1:0] received_inc;

    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    assign count_dec    = (r_count != '0) ? r_count - 16'd1 : r_count;
    assign length       = {r_len_hi, r_in_byte};
    assign length_m1    = length - 16'd1;
    assign received_inc = r_received + 16'd1;

    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_len_hi    = r_len_hi;
        n_expected  = r_expected;
        n_received  = r_received;
        n_opcode    = r_opcode;
        n_sum       = r_sum;
        n_res_valid = 1'b0;
        n_res       = '{kind: KIND_PARAM, param_byte: '0, param_index: '0,
                        packet_opcode: r_opcode, param_count: r_expected, last: 1'b1};
        if (r_in_action) begin
            if (r_phase != PH_IDLE) begin
                n_count = count_dec;
                if (count_dec == '0) begin
                    n_phase      = PH_IDLE;
                    n_res_valid  = 1'b1;
                    n_res.kind   = KIND_TIMEOUT;
                end
            end
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (r_in_byte == r_start_byte) begin
                        n_phase    = PH_LEN_HI;
                        n_count    = r_timeout_reload;
                        n_len_hi   = '0;
                        n_expected = '0;
                        n_received = '0;
                        n_opcode   = '0;
                        n_sum      = '0;
                    end
                end
                PH_LEN_HI: begin
                    n_len_hi = r_in_byte;
                    n_sum    = r_sum + r_in_byte;
                    n_phase  = PH_LEN_LO;
                    n_count  = count_dec;
                end
                PH_LEN_LO: begin
                    n_sum   = r_sum + r_in_byte;
                    n_count = count_dec;
                    if (length == '0 || length_m1 > r_max_params) begin
                        n_phase             = PH_IDLE;
                        n_res_valid         = 1'b1;
                        n_res.kind          = KIND_LEN_ERR;
                        n_res.packet_opcode = '0;
                        n_res.param_count   = (length == '0) ? '0 : length_m1;
                    end else begin
                        n_expected = length_m1;
                        n_phase    = PH_OPCODE;
                    end
                end
                PH_OPCODE: begin
                    n_opcode = r_in_byte;
                    n_sum    = r_sum + r_in_byte;
                    n_phase  = (r_expected == '0) ? PH_CHECK : PH_PARAMS;
                    n_count  = count_dec;
                end
                PH_PARAMS: begin
                    n_res_valid       = 1'b1;
                    n_res.kind        = KIND_PARAM;
                    n_res.param_byte  = r_in_byte;
                    n_res.param_index = r_received;
                    n_res.last        = 1'b0;
                    n_sum             = r_sum + r_in_byte;
                    n_received        = received_inc;
                    n_count           = count_dec;
                    if (received_inc >= r_expected) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    n_phase     = PH_IDLE;
                    n_count     = count_dec;
                    n_res_valid = 1'b1;
                    n_res.kind  = (BYTE_W'(r_sum + r_in_byte) == '0) ? KIND_GOOD
                                                                     : KIND_BAD_SUM;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte     <= START_BYTE_RST;
            r_timeout_reload <= TIMEOUT_RST;
            r_max_params     <= MAX_PARAMS_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_START_BYTE: r_start_byte     <= i_cfg.data[BYTE_W-1:0];
                CFG_TIMEOUT:    r_timeout_reload <= i_cfg.data;
                CFG_MAX_PARAMS: r_max_params     <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_action <= i_req.action;
            r_in_byte   <= i_req.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_count    <= TIMEOUT_RST;
            r_len_hi   <= '0;
            r_expected <= '0;
            r_received <= '0;
            r_opcode   <= '0;
            r_sum      <= '0;
        end else if (advance) begin
            r_phase    <= n_phase;
            r_count    <= n_count;
            r_len_hi   <= n_len_hi;
            r_expected <= n_expected;
            r_received <= n_received;
            r_opcode   <= n_opcode;
            r_sum      <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= n_res_valid;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && n_res_valid) begin
            r_out <= n_res;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.kind          = r_out.kind;
    assign o_res.param_byte    = r_out.param_byte;
    assign o_res.param_index   = r_out.param_index;
    assign o_res.packet_opcode = r_out.packet_opcode;
    assign o_res.param_count   = r_out.param_count;
    assign o_res.last          = r_out.last;

endmodule

FILE: hw/rtl/uedf_checker.sv
// ----------------------------------------------------------------------------
// uedf_checker
// Port-level checks on the result channel of the packet deframer.
// ----------------------------------------------------------------------------
module uedf_checker import uedf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_ready,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [BYTE_W-1:0] i_param_byte,
    input  logic [WORD_W-1:0] i_param_index,
    input  logic [BYTE_W-1:0] i_packet_opcode,
    input  logic              i_last
);

    a_last_marks_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_last == (i_kind != KIND_PARAM)))
        else $error("last does not match result kind");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_kind <= KIND_TIMEOUT))
        else $error("result kind out of range");

    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_kind != KIND_PARAM) |-> (i_param_byte == '0 && i_param_index == '0))
        else $error("status result carries parameter data");

    a_len_err_opcode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_kind == KIND_LEN_ERR) |-> (i_packet_opcode == '0))
        else $error("length error carries an opcode");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> (i_valid && $stable(i_kind) && $stable(i_param_byte)))
        else $error("stalled result changed");

endmodule

bind uart_event_packet_deframer uedf_checker u_uedf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (o_res.valid),
    .i_ready         (o_res.ready),
    .i_kind          (o_res.kind),
    .i_param_byte    (o_res.param_byte),
    .i_param_index   (o_res.param_index),
    .i_packet_opcode (o_res.packet_opcode),
    .i_last          (o_res.last)
);

FILE: tb/uart_event_packet_deframer_test.sv
// ----------------------------------------------------------------------------
// uart_event_packet_deframer_test
// Drives byte and tick requests into the packet deframer through its valid /
// ready channels, predicts every parameter byte and end-of-packet status in
// a scoreboard that tracks the framing state, and compares each result field
// by field. Covers good and bad checksums, length errors, timeouts and
// register settings at their extremes, under random sender gaps and
// receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module uart_event_packet_deframer_test;
    import uedf_pkg::*;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int ITEMS_PER_PHASE = 280;

    typedef enum logic [2:0] {
        ST_HUNT, ST_LEN_HI, ST_LEN_LO, ST_OPCODE, ST_PARAMS, ST_CHECKSUM
    } t_rx_state;

    typedef enum int {PACE_FREE, PACE_RANDOM, PACE_PERIODIC, PACE_LONG} t_rx_pace;

    class t_deframe_scoreboard;
        logic [BYTE_W-1:0] start_byte;
        logic [WORD_W-1:0] reload;
        logic [WORD_W-1:0] max_params;
        t_rx_state         st;
        logic [WORD_W-1:0] tmo_count;
        logic [BYTE_W-1:0] len_hi;
        logic [WORD_W-1:0] exp_params;
        logic [WORD_W-1:0] received;
        logic [BYTE_W-1:0] opcode;
        logic [BYTE_W-1:0] sum;
        t_result           due_results[$];
        int                fail_count;
        int                effective;

        function new();
            start_byte = START_BYTE_RST;
            reload     = TIMEOUT_RST;
            max_params = MAX_PARAMS_RST;
            st         = ST_HUNT;
            tmo_count  = TIMEOUT_RST;
            len_hi     = '0;
            exp_params = '0;
            received   = '0;
            opcode     = '0;
            sum        = '0;
            fail_count = 0;
            effective  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
            unique case (idx)
                CFG_START_BYTE: start_byte = data[BYTE_W-1:0];
                CFG_TIMEOUT:    reload = data;
                CFG_MAX_PARAMS: max_params = data;
                default: ;
            endcase
        endfunction

        function void count_down();
            if (tmo_count != 0) tmo_count--;
        endfunction

        function void queue_result(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] pb,
                                   logic [WORD_W-1:0] pi, logic [BYTE_W-1:0] opc,
                                   logic [WORD_W-1:0] pc, logic lst);
            t_result r;
            r.kind          = kind;
            r.param_byte    = pb;
            r.param_index   = pi;
            r.packet_opcode = opc;
            r.param_count   = pc;
            r.last          = lst;
            due_results.push_back(r);
        endfunction

        // advance the framing state by one request and queue what it produces
        function void note_request(logic act, logic [BYTE_W-1:0] b);
            logic [WORD_W-1:0] len;
            logic [BYTE_W-1:0] cs;
            if (act == ACT_TICK) begin
                if (st == ST_HUNT) return;
                effective++;
                count_down();
                if (tmo_count == 0) begin
                    st = ST_HUNT;
                    queue_result(KIND_TIMEOUT, '0, '0, opcode, exp_params, 1'b1);
                end
                return;
            end
            if (st != ST_HUNT || b == start_byte) effective++;
            unique case (st)
                ST_HUNT: begin
                    if (b == start_byte) begin
                        st         = ST_LEN_HI;
                        tmo_count  = reload;
                        len_hi     = '0;
                        exp_params = '0;
                        received   = '0;
                        opcode     = '0;
                        sum        = '0;
                    end
                end
                ST_LEN_HI: begin
                    len_hi = b;
                    sum    = sum + b;
                    st     = ST_LEN_LO;
                    count_down();
                end
                ST_LEN_LO: begin
                    sum = sum + b;
                    count_down();
                    len = {len_hi, b};
                    if (len == 0 || len - 16'd1 > max_params) begin
                        st = ST_HUNT;
                        queue_result(KIND_LEN_ERR, '0, '0, '0,
                                     (len == 0) ? 16'd0 : len - 16'd1, 1'b1);
                    end else begin
                        exp_params = len - 16'd1;
                        st         = ST_OPCODE;
                    end
                end
                ST_OPCODE: begin
                    opcode = b;
                    sum    = sum + b;
                    st     = (exp_params == 0) ? ST_CHECKSUM : ST_PARAMS;
                    count_down();
                end
                ST_PARAMS: begin
                    queue_result(KIND_PARAM, b, received, opcode, exp_params, 1'b0);
                    sum      = sum + b;
                    received = received + 16'd1;
                    if (received >= exp_params) st = ST_CHECKSUM;
                    count_down();
                end
                default: begin
                    cs = 8'h00 - sum;
                    st = ST_HUNT;
                    count_down();
                    queue_result((cs == b) ? KIND_GOOD : KIND_BAD_SUM, '0, '0,
                                 opcode, exp_params, 1'b1);
                end
            endcase
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (due_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: kind %0d byte %02h index %0d opcode %02h",
                             got.kind, got.param_byte, got.param_index, got.packet_opcode);
                return;
            end
            want = due_results.pop_front();
            if (got.kind !== want.kind || got.param_byte !== want.param_byte ||
                got.param_index !== want.param_index ||
                got.packet_opcode !== want.packet_opcode ||
                got.param_count !== want.param_count || got.last !== want.last) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("mismatch expected: kind %0d byte %02h index %0d opcode %02h",
                             want.kind, want.param_byte, want.param_index,
                             want.packet_opcode, " count %0d last %0d",
                             want.param_count, want.last);
                    $display("mismatch actual:   kind %0d byte %02h index %0d opcode %02h",
                             got.kind, got.param_byte, got.param_index,
                             got.packet_opcode, " count %0d last %0d",
                             got.param_count, got.last);
                end
            end
        endfunction

        function int pending();
            return due_results.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    uedf_in_if  req_if ();
    uedf_out_if res_if ();
    uedf_cfg_if cfg_if ();

    uart_event_packet_deframer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    t_deframe_scoreboard sb;
    t_rx_pace            pace;
    bit                  no_gaps;
    int                  burst_left;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready)
                sb.note_request(req_if.action, req_if.rx_byte);
            if (res_if.valid && res_if.ready)
                sb.check_result({res_if.kind, res_if.param_byte, res_if.param_index,
                                 res_if.packet_opcode, res_if.param_count, res_if.last});
        end
    end

    // result receiver
    initial begin
        int          hold;
        int unsigned cyc;
        hold = 0;
        cyc  = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            case (pace)
                PACE_FREE:     res_if.ready <= 1'b1;
                PACE_RANDOM:   res_if.ready <= ($urandom_range(0, 3) != 0);
                PACE_PERIODIC: res_if.ready <= ((cyc % 7) < 4);
                default: begin
                    if (hold > 0) begin
                        hold--;
                        res_if.ready <= 1'b0;
                    end else if ($urandom_range(0, 15) == 0) begin
                        hold = $urandom_range(1, 12);
                        res_if.ready <= 1'b0;
                    end else begin
                        res_if.ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    task automatic send_item(input logic act, input logic [BYTE_W-1:0] b);
        req_if.valid   <= 1'b1;
        req_if.action  <= act;
        req_if.rx_byte <= b;
        do @(posedge i_clk); while (!req_if.ready);
        if (!no_gaps) begin
            if (burst_left == 0) begin
                req_if.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                burst_left = $urandom_range(1, 24);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic put_byte(input logic [BYTE_W-1:0] b, input int tick_pct);
        if ($urandom_range(0, 99) < tick_pct) send_item(ACT_TICK, 8'($urandom));
        send_item(ACT_BYTE, b);
    endtask

    // finish whatever packet is open, by ticks when that is shorter
    task automatic settle();
        while (sb.st != ST_HUNT) begin
            if (sb.st == ST_PARAMS && sb.exp_params - sb.received > sb.tmo_count)
                send_item(ACT_TICK, 8'($urandom));
            else if (sb.st == ST_LEN_HI || sb.st == ST_LEN_LO)
                send_item(ACT_BYTE, 8'h00);
            else
                send_item(ACT_BYTE, 8'($urandom));
        end
    endtask

    task automatic send_packet(input logic [WORD_W-1:0] len, input logic [BYTE_W-1:0] opc,
                               input bit good_sum, input int tick_pct);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        settle();
        send_item(ACT_BYTE, sb.start_byte);
        put_byte(len[15:8], tick_pct);
        put_byte(len[7:0], tick_pct);
        if (len == 0 || len - 16'd1 > sb.max_params) return;
        sum = len[15:8] + len[7:0] + opc;
        put_byte(opc, tick_pct);
        for (int k = 1; k < len; k++) begin
            b = 8'($urandom);
            sum = sum + b;
            put_byte(b, tick_pct);
        end
        b = 8'h00 - sum;
        if (!good_sum) b = b ^ 8'($urandom_range(1, 255));
        put_byte(b, tick_pct);
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [BYTE_W-1:0] sv, input logic [WORD_W-1:0] tv,
                              input logic [WORD_W-1:0] mv);
        logic [CFG_IDX_W-1:0] idx_list[4];
        logic [WORD_W-1:0]    data_list[4];
        idx_list  = '{CFG_START_BYTE, CFG_TIMEOUT, CFG_MAX_PARAMS, CFG_SPARE};
        data_list = '{{8'($urandom), sv}, tv, mv, 16'($urandom)};
        for (int k = 0; k < 4; k++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= idx_list[k];
            cfg_if.data  <= data_list[k];
            do @(posedge i_clk); while (!cfg_if.ready);
            sb.write_reg(idx_list[k], data_list[k]);
        end
        cfg_if.valid <= 1'b0;
    endtask

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        int                r;
        int                sel;
        int                mx;
        int                len;
        int                pct;
        int                target;
        bit                paused;
        logic [BYTE_W-1:0] sv;
        logic [WORD_W-1:0] tv;
        logic [WORD_W-1:0] mv;

        sb         = new();
        pace       = PACE_RANDOM;
        no_gaps    = 1'b0;
        burst_left = 4;
        paused     = 1'b0;
        i_rst_n        <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.action  <= ACT_BYTE;
        req_if.rx_byte <= '0;
        cfg_if.valid   <= 1'b0;
        cfg_if.index   <= CFG_START_BYTE;
        cfg_if.data    <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // idle tick and noise, zero params, bad checksum, length errors
        send_item(ACT_TICK, 8'hFF);
        send_item(ACT_BYTE, 8'h55);
        send_packet(16'd1, 8'hFF, 1'b1, 0);
        send_packet(16'd3, 8'h00, 1'b0, 0);
        send_packet(16'd0, 8'h00, 1'b1, 0);
        send_packet(16'hFFFF, 8'h00, 1'b1, 0);
        send_packet(16'd2, 8'hA5, 1'b1, 50);

        // tick on a counter already at zero
        drain();
        write_regs(sb.start_byte, 16'd3, sb.max_params);
        send_item(ACT_BYTE, sb.start_byte);
        send_item(ACT_BYTE, 8'h00);
        send_item(ACT_BYTE, 8'h01);
        send_item(ACT_BYTE, 8'h5A);
        send_item(ACT_TICK, 8'h00);

        // new reload leaves the running count alone
        send_item(ACT_BYTE, sb.start_byte);
        send_item(ACT_BYTE, 8'h00);
        drain();
        write_regs(sb.start_byte, 16'd1000, sb.max_params);
        send_item(ACT_TICK, 8'h00);
        send_item(ACT_TICK, 8'h00);

        for (int p = 0; p < 6; p++) begin
            drain();
            case (p)
                0: begin
                    sv = START_BYTE_RST; tv = TIMEOUT_RST; mv = MAX_PARAMS_RST;
                    pace = PACE_RANDOM; no_gaps = 1'b0;
                end
                1: begin
                    sv = 8'h00; tv = 16'hFFFF; mv = 16'hFFFE;
                    pace = PACE_FREE; no_gaps = 1'b1;
                end
                2: begin
                    sv = 8'hFF; tv = 16'd1; mv = 16'd0;
                    pace = PACE_PERIODIC; no_gaps = 1'b0;
                end
                3: begin
                    sv = 8'($urandom); tv = 16'($urandom_range(4, 30));
                    mv = 16'($urandom_range(0, 12));
                    pace = PACE_LONG; no_gaps = 1'b0;
                end
                4: begin
                    sv = 8'($urandom); tv = 16'($urandom_range(20, 200));
                    mv = 16'($urandom_range(300, 65534));
                    pace = PACE_RANDOM; no_gaps = 1'b0;
                end
                default: begin
                    sv = 8'($urandom); tv = 16'($urandom_range(1, 65535));
                    mv = 16'($urandom_range(0, 65534));
                    pace = PACE_LONG; no_gaps = 1'b0;
                end
            endcase
            write_regs(sv, tv, mv);

            target = sb.effective + ITEMS_PER_PHASE;
            while (sb.effective < target) begin
                r   = $urandom_range(0, 99);
                pct = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : 0;
                if (r < 75) begin
                    mx  = sb.max_params;
                    sel = $urandom_range(0, 99);
                    if (sel < 60)
                        len = 1 + $urandom_range(0, (mx < 8) ? mx : 8);
                    else if (sel < 80)
                        len = 1 + $urandom_range(0, (mx < 40) ? mx : 40);
                    else if (sel < 86)
                        len = 0;
                    else if (sel < 94 && mx < 65534)
                        len = mx + 2 + $urandom_range(0, 65533 - mx);
                    else
                        len = 1 + $urandom_range(0, (mx < 300) ? mx : 300);
                    send_packet(16'(len), 8'($urandom), $urandom_range(0, 5) != 0, pct);
                end else if (r < 88) begin
                    // truncated packet left to the timer
                    settle();
                    send_item(ACT_BYTE, sb.start_byte);
                    send_item(ACT_BYTE, 8'($urandom_range(0, 1)));
                    repeat ($urandom_range(0, 3)) send_item(ACT_BYTE, 8'($urandom));
                    repeat ($urandom_range(1, 6)) send_item(ACT_TICK, 8'($urandom));
                end else begin
                    repeat ($urandom_range(1, 4))
                        send_item(1'($urandom_range(0, 1)), 8'($urandom));
                end
                if (p == 3 && !paused && sb.effective >= target - 150) begin
                    drain();
                    paused = 1'b1;
                end
            end
        end

        req_if.valid <= 1'b0;
        for (int k = 0; k < 200000 && sb.pending() != 0; k++) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/uedf_pkg.sv
hw/rtl/uedf_if.sv
hw/rtl/uart_event_packet_deframer.sv
hw/rtl/uedf_checker.sv
tb/uart_event_packet_deframer_test.sv
